### rtl/atpg_pkg.sv
// Shared types and constants for the alarm tone pattern generator.
// No dependencies; imported by the top level and its checker.
package atpg_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_BEEP1  = 3'd1,
      PH_PAUSE1 = 3'd2,
      PH_BEEP2  = 3'd3,
      PH_PAUSE2 = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      MUTE_NONE  = 2'd0,
      MUTE_SET   = 2'd1,
      MUTE_CLEAR = 2'd2
   } mute_cmd_type;

   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_CRITICAL = 3'd1;
   localparam logic [2:0] KIND_FULL     = 3'd2;
   localparam logic [2:0] KIND_LEAKAGE  = 3'd3;
   localparam logic [2:0] KIND_BLOCKAGE = 3'd4;
   localparam logic [2:0] KIND_LOW_BATT = 3'd5;

   localparam logic REG_BEEP_LIMIT = 1'b0;
   localparam logic REG_MUTE_LIMIT = 1'b1;

   localparam logic [15:0] BEEP_LIMIT_RESET = 16'd1500;
   localparam logic [15:0] MUTE_LIMIT_RESET = 16'd15000;

   localparam logic [7:0] LONG_ON_TICKS     = 8'd30;
   localparam logic [7:0] LONG_PERIOD_TICKS = 8'd40;
   localparam logic [7:0] CHIRP_ON_TICKS    = 8'd5;
   localparam logic [7:0] CHIRP_PERIOD      = 8'd100;
   localparam logic [7:0] BEEP_STEP_TICKS   = 8'd10;
   localparam logic [7:0] BEEP_GAP_TICKS    = 8'd100;
   localparam logic [5:0] BLINK_ON_TICKS    = 6'd25;
   localparam logic [5:0] BLINK_PERIOD      = 6'd50;

endpackage

### rtl/alarm_tone_pattern_generator_top.sv
// Alarm tone pattern generator: tick stream in, buzzer/LED/status stream out.
// Ticks pass the input, then the output register; one per cycle unless stalled.
// Throughput is set by the single registered update of the tone/mute state.
// An input register and an output register part the two stream sides.
// Synchronous active-high reset clears state, stage valids and loads the
// default limits (beep 1500, mute 15000). Depends on atpg_pkg.
module alarm_tone_pattern_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // battery_empty, battery_low, charging, canister_full, leakage, blockage,
   // mute_cmd[7:6]
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // buzzer_on, green_led_on, alarm_kind[4:2], alarm_on, muted, zero pad
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   import atpg_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic        advance;

   logic [15:0] beep_limit_ff, mute_limit_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  ptimer_ff, ptimer_in;
   logic [5:0]  blink_ff, blink_in;
   logic [15:0] runtime_ff, runtime_in;
   logic [15:0] mcount_ff, mcount_in;
   logic        mute_ff, mute_in;
   logic        buzz_ff, buzz_in;
   logic        led_ff, led_in;
   logic [2:0]  kind;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;

   always_comb begin
      logic empty, low, chg, full, leak, block;
      logic [1:0] cmd;
      empty = in_data_ff[0];
      low   = in_data_ff[1];
      chg   = in_data_ff[2];
      full  = in_data_ff[3];
      leak  = in_data_ff[4];
      block = in_data_ff[5];
      cmd   = in_data_ff[7:6];

      phase_in   = phase_ff;
      ptimer_in  = ptimer_ff;
      blink_in   = blink_ff;
      runtime_in = runtime_ff;
      mcount_in  = mcount_ff;
      mute_in    = mute_ff;
      buzz_in    = buzz_ff;
      led_in     = led_ff;

      case (cmd)
         MUTE_SET: begin
            mute_in   = 1'b1;
            mcount_in = 16'd0;
            buzz_in   = 1'b0;
         end
         MUTE_CLEAR: begin
            mute_in = 1'b0;
         end
         default: begin
         end
      endcase

      if (empty && !chg)      kind = KIND_CRITICAL;
      else if (full)          kind = KIND_FULL;
      else if (leak)          kind = KIND_LEAKAGE;
      else if (block)         kind = KIND_BLOCKAGE;
      else if (low && !chg)   kind = KIND_LOW_BATT;
      else                    kind = KIND_NONE;

      if (kind != KIND_NONE) begin
         blink_in = blink_ff + 6'd1;
         if (blink_ff < BLINK_ON_TICKS) led_in = 1'b1;
         else if (blink_in < BLINK_PERIOD) led_in = 1'b0;
         else blink_in = 6'd0;

         if (mute_in) begin
            buzz_in = 1'b0;
         end else begin
            if (kind == KIND_CRITICAL || kind == KIND_FULL) begin
               ptimer_in = ptimer_ff + 8'd1;
               if (ptimer_ff < LONG_ON_TICKS) buzz_in = 1'b1;
               else if (ptimer_in < LONG_PERIOD_TICKS) buzz_in = 1'b0;
               else ptimer_in = 8'd0;
            end else if (kind == KIND_LEAKAGE || kind == KIND_BLOCKAGE) begin
               ptimer_in = ptimer_ff + 8'd1;
               case (phase_ff)
                  PH_IDLE: begin
                     phase_in  = PH_BEEP1;
                     ptimer_in = 8'd0;
                  end
                  PH_BEEP1: begin
                     buzz_in = 1'b1;
                     if (ptimer_ff >= BEEP_STEP_TICKS) begin
                        phase_in  = PH_PAUSE1;
                        ptimer_in = 8'd0;
                     end
                  end
                  PH_PAUSE1: begin
                     buzz_in = 1'b0;
                     if (ptimer_ff >= BEEP_STEP_TICKS) begin
                        phase_in  = PH_BEEP2;
                        ptimer_in = 8'd0;
                     end
                  end
                  PH_BEEP2: begin
                     buzz_in = 1'b1;
                     if (ptimer_ff >= BEEP_STEP_TICKS) begin
                        phase_in  = PH_PAUSE2;
                        ptimer_in = 8'd0;
                     end
                  end
                  PH_PAUSE2: begin
                     buzz_in = 1'b0;
                     if (ptimer_ff >= BEEP_GAP_TICKS) begin
                        phase_in  = PH_IDLE;
                        ptimer_in = 8'd0;
                     end
                  end
                  default: begin
                     phase_in  = PH_IDLE;
                     ptimer_in = ptimer_ff;
                  end
               endcase
            end else begin
               ptimer_in = ptimer_ff + 8'd1;
               if (ptimer_ff < CHIRP_ON_TICKS) buzz_in = 1'b1;
               else if (ptimer_in < CHIRP_PERIOD) buzz_in = 1'b0;
               else ptimer_in = 8'd0;
            end

            if (runtime_ff > beep_limit_ff) begin
               buzz_in    = 1'b0;
               runtime_in = 16'd0;
            end else begin
               runtime_in = runtime_ff + 16'd1;
            end
         end
      end else begin
         led_in   = 1'b1;
         buzz_in  = 1'b0;
         phase_in = PH_IDLE;
      end

      if (mute_in) begin
         if (mcount_in >= mute_limit_ff) begin
            mute_in   = 1'b0;
            mcount_in = 16'd0;
         end else begin
            mcount_in = mcount_in + 16'd1;
         end
      end

      out_data_in = {1'b0, mute_in, kind != KIND_NONE, kind, led_in, buzz_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         beep_limit_ff <= BEEP_LIMIT_RESET;
         mute_limit_ff <= MUTE_LIMIT_RESET;
         phase_ff      <= PH_IDLE;
         ptimer_ff     <= 8'd0;
         blink_ff      <= 6'd0;
         runtime_ff    <= 16'd0;
         mcount_ff     <= 16'd0;
         mute_ff       <= 1'b0;
         buzz_ff       <= 1'b0;
         led_ff        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            case (csr_addr)
               REG_BEEP_LIMIT: beep_limit_ff <= csr_wdata;
               REG_MUTE_LIMIT: mute_limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (advance) begin
            phase_ff   <= phase_in;
            ptimer_ff  <= ptimer_in;
            blink_ff   <= blink_in;
            runtime_ff <= runtime_in;
            mcount_ff  <= mcount_in;
            mute_ff    <= mute_in;
            buzz_ff    <= buzz_in;
            led_ff     <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) in_data_ff <= req_tdata;
      if (advance) out_data_ff <= out_data_in;
   end

endmodule

### rtl/atpg_checker.sv
// Port-level checks on the alarm tone pattern generator, and their bind.
// Depends on atpg_pkg and alarm_tone_pattern_generator_top.
module atpg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import atpg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_active_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5] == (rsp_tdata[4:2] != KIND_NONE))
      else $error("alarm flag disagrees with alarm_kind");

   a_idle_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:2] == KIND_NONE |-> !rsp_tdata[0] && rsp_tdata[1])
      else $error("buzzer or LED wrong with no alarm");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:2] <= KIND_LOW_BATT && !rsp_tdata[7])
      else $error("alarm_kind out of range or pad bit set");

endmodule

bind alarm_tone_pattern_generator_top atpg_checker u_atpg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
